FILE: design/mbet_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// No dependencies; every other file in the design imports this package.
`default_nettype none

package mbet_pkg;

   // Screen geometry and loop bound
   localparam int HALF_WIDTH  = 320;
   localparam int HALF_HEIGHT = 240;
   localparam int MAX_ITER    = 255;

   // Q5.27 coordinates, Q10.54 squares
   localparam int FRAC_BITS   = 27;
   localparam int COORD_W     = 32;
   localparam int PROD_W      = 64;
   localparam int CENTER_W    = 30;
   localparam int PIX_X_W     = 10;
   localparam int PIX_Y_W     = 9;
   localparam int GRAY_W      = 8;

   // Pixel offset d * 2^27 / 200, rounded half away from zero:
   // q = |d| * RECIP_HI + floor((16|d| + 12) / 25), the small quotient
   // taken as (t * RECIP_LO) >> RECIP_SHIFT, exact for t below 2^14.
   localparam int DELTA_W     = 11;
   localparam int MAG_W       = 10;
   localparam int LOW_T_W     = 14;
   localparam logic [31:0] RECIP_HI    = 32'd671088;
   localparam logic [31:0] RECIP_LO    = 32'd20972;
   localparam logic [13:0] LOW_T_BIAS  = 14'd12;
   localparam int          RECIP_SHIFT = 19;

   // Escape bound 4.0 in Q10.54
   localparam logic [PROD_W:0] ESCAPE_LIMIT = 65'(4) << (2 * FRAC_BITS);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_CENTER_REAL = 1'b0;
   localparam logic REG_CENTER_IMAG = 1'b1;
   localparam logic signed [CENTER_W-1:0] CENTER_REAL_RESET = -30'sd100663296;
   localparam logic signed [CENTER_W-1:0] CENTER_IMAG_RESET = 30'sd0;

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_real;
      logic signed [CENTER_W-1:0] center_imag;
   } center_type;

   typedef struct packed {
      logic              valid;
      logic [GRAY_W-1:0] gray_level;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_XH,
      ST_MAP_XL,
      ST_MAP_YH,
      ST_MAP_YL,
      ST_MAP_CI,
      ST_SQ_R,
      ST_SQ_I,
      ST_TEST,
      ST_UPD,
      ST_DONE
   } state_type;

   // Clamp a widened sum to the signed 32-bit coordinate range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [35:0] v);
      logic signed [35:0] hi_lim;
      logic signed [35:0] lo_lim;
      hi_lim = 36'sh0_7FFF_FFFF;
      lo_lim = -36'sh0_8000_0000;
      if (v > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo_lim) begin
         return 32'sh8000_0000;
      end else begin
         return v[COORD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/mbet_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbet_pkg for widths.
`default_nettype none

module mbet_mul
   import mbet_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [COORD_W-1:0] op_a,
   input  wire logic signed [COORD_W-1:0] op_b,
   output logic signed [PROD_W-1:0]       prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // Full-precision signed product
   assign prod_in = op_a * op_b;

   // Register the product; one result per cycle
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

FILE: design/mbet_csr.sv
// APB-style register file holding the view center (two signed Q3.27 values).
// Depends on mbet_pkg for the register map and reset values.
`default_nettype none

module mbet_csr
   import mbet_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output center_type                 center
);

   center_type center_ff;
   center_type center_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];
   assign center     = center_ff;

   // Decode the write beat
   always_comb begin
      center_in = center_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_CENTER_REAL: center_in.center_real = csr_pwdata[CENTER_W-1:0];
            REG_CENTER_IMAG: center_in.center_imag = csr_pwdata[CENTER_W-1:0];
            default: center_in = center_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff.center_real <= CENTER_REAL_RESET;
         center_ff.center_imag <= CENTER_IMAG_RESET;
      end else begin
         center_ff <= center_in;
      end
   end

   // Read back, sign-extended to the bus width
   always_comb begin
      unique case (reg_sel)
         REG_CENTER_REAL: csr_prdata = 32'(center_ff.center_real);
         REG_CENTER_IMAG: csr_prdata = 32'(center_ff.center_imag);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/mbet_core.sv
// Sequencer and datapath: maps a pixel to c, then runs z = z*z + c on the
// shared multiplier. Depends on mbet_pkg and instantiates mbet_mul.
`default_nettype none

module mbet_core
   import mbet_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [PIX_X_W-1:0] req_pixel_x,
   input  wire logic [PIX_Y_W-1:0] req_pixel_y,
   input  wire center_type         center,
   input  wire logic               slot_free,
   output result_type              result
);

   state_type state_ff, state_in;

   logic [MAG_W-1:0]          mag_x_ff, mag_x_in;
   logic [MAG_W-1:0]          mag_y_ff, mag_y_in;
   logic                      neg_x_ff, neg_x_in;
   logic                      neg_y_ff, neg_y_in;
   logic [COORD_W-1:0]        part_ff, part_in;
   logic signed [COORD_W-1:0] cr_ff, cr_in;
   logic signed [COORD_W-1:0] ci_ff, ci_in;
   logic signed [COORD_W-1:0] zr_ff, zr_in;
   logic signed [COORD_W-1:0] zi_ff, zi_in;
   logic signed [PROD_W-1:0]  rr_ff, rr_in;
   logic signed [PROD_W-1:0]  diff_ff, diff_in;
   logic [GRAY_W-1:0]         iter_ff, iter_in;

   logic signed [COORD_W-1:0] op_a;
   logic signed [COORD_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod_ff;

   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;
   logic [LOW_T_W-1:0]        t_x;
   logic [LOW_T_W-1:0]        t_y;
   logic [COORD_W-1:0]        quot;
   logic signed [COORD_W-1:0] offset_x;
   logic signed [COORD_W-1:0] offset_y;
   logic [PROD_W:0]           mag_sum;
   logic                      escape;
   logic signed [35:0]        zr_sum;
   logic signed [35:0]        zi_sum;

   mbet_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // Pixel deltas from screen center
   assign dx  = $signed({1'b0, req_pixel_x}) - DELTA_W'(HALF_WIDTH);
   assign dy  = $signed({2'b0, req_pixel_y}) - DELTA_W'(HALF_HEIGHT);
   assign t_x = {mag_x_ff, 4'b0} + LOW_T_BIAS;
   assign t_y = {mag_y_ff, 4'b0} + LOW_T_BIAS;

   // Rounded quotient: high part plus corrected low part
   assign quot     = part_ff + COORD_W'(prod_ff[31:RECIP_SHIFT]);
   assign offset_x = neg_x_ff ? -$signed(quot) : $signed(quot);
   assign offset_y = neg_y_ff ? -$signed(quot) : $signed(quot);

   // Escape test on |z|^2 (both squares non-negative), or loop end at MAX_ITER
   assign mag_sum = {1'b0, rr_ff} + {1'b0, prod_ff};
   assign escape  = (iter_ff == GRAY_W'(MAX_ITER)) || (mag_sum > ESCAPE_LIMIT);

   // Floor back to Q5.27 and add c
   assign zr_sum = 36'(diff_ff >>> FRAC_BITS) + 36'(cr_ff);
   assign zi_sum = 36'(prod_ff >>> (FRAC_BITS - 1)) + 36'(ci_ff);

   // Next state, multiplier operands and datapath updates
   always_comb begin
      state_in  = state_ff;
      mag_x_in  = mag_x_ff;
      mag_y_in  = mag_y_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      part_in   = part_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      rr_in     = rr_ff;
      diff_in   = diff_ff;
      iter_in   = iter_ff;
      op_a      = '0;
      op_b      = '0;
      req_stall = 1'b1;
      result    = '{valid: 1'b0, gray_level: GRAY_W'(MAX_ITER) - iter_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               neg_x_in = dx[DELTA_W-1];
               neg_y_in = dy[DELTA_W-1];
               mag_x_in = MAG_W'(dx[DELTA_W-1] ? -dx : dx);
               mag_y_in = MAG_W'(dy[DELTA_W-1] ? -dy : dy);
               state_in = ST_MAP_XH;
            end
         end
         ST_MAP_XH: begin
            op_a     = COORD_W'(mag_x_ff);
            op_b     = RECIP_HI;
            state_in = ST_MAP_XL;
         end
         ST_MAP_XL: begin
            op_a     = COORD_W'(t_x);
            op_b     = RECIP_LO;
            part_in  = prod_ff[COORD_W-1:0];
            state_in = ST_MAP_YH;
         end
         ST_MAP_YH: begin
            op_a     = COORD_W'(mag_y_ff);
            op_b     = RECIP_HI;
            cr_in    = COORD_W'(center.center_real) + offset_x;
            state_in = ST_MAP_YL;
         end
         ST_MAP_YL: begin
            op_a     = COORD_W'(t_y);
            op_b     = RECIP_LO;
            part_in  = prod_ff[COORD_W-1:0];
            state_in = ST_MAP_CI;
         end
         ST_MAP_CI: begin
            ci_in    = COORD_W'(center.center_imag) + offset_y;
            zr_in    = '0;
            zi_in    = '0;
            iter_in  = '0;
            state_in = ST_SQ_R;
         end
         ST_SQ_R: begin
            op_a     = zr_ff;
            op_b     = zr_ff;
            state_in = ST_SQ_I;
         end
         ST_SQ_I: begin
            op_a     = zi_ff;
            op_b     = zi_ff;
            rr_in    = prod_ff;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            op_a    = zr_ff;
            op_b    = zi_ff;
            diff_in = rr_ff - prod_ff;
            if (escape) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            zr_in    = sat32(zr_sum);
            zi_in    = sat32(zi_sum);
            iter_in  = iter_ff + 1'b1;
            state_in = ST_SQ_R;
         end
         ST_DONE: begin
            if (slot_free) begin
               result.valid = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      part_ff  <= part_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      rr_ff    <= rr_in;
      diff_ff  <= diff_in;
      iter_ff  <= iter_in;
   end

endmodule

`default_nettype wire

FILE: design/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time pixel shader: register file,
// iteration core and the result output register. Depends on mbet_pkg.
//
//   channel  | direction | beat contents
//   ---------+-----------+--------------------------------------
//   req_     | in        | pixel_x (10b), pixel_y (9b)
//   rsp_     | out       | gray_level (8b)
//   csr_     | in/out    | center_real @0x0, center_imag @0x4
//
// One pixel is held from accept to result, running 0..255 z updates on the
// way; the next pixel can be accepted in the cycle the result appears.
// The pace is set by the single 32x32 multiplier: three products per update
// plus an update state, and four products to map the pixel to c. Reset is
// synchronous and clears the sequencer, the output valid and the center
// registers. A stalled result waits in the output register while the next
// pixel is accepted.
`default_nettype none

module mandelbrot_escape_time
   import mbet_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PIX_X_W-1:0]    req_pixel_x,
   input  wire logic [PIX_Y_W-1:0]    req_pixel_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [GRAY_W-1:0]          rsp_gray_level,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   center_type        center;
   result_type        result;
   logic              slot_free;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GRAY_W-1:0] gray_ff, gray_in;

   mbet_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .center      (center)
   );

   mbet_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .center      (center),
      .slot_free   (slot_free),
      .result      (result)
   );

   // Output slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Load a finished result, drop a delivered beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      gray_in      = gray_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         gray_in      = result.gray_level;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gray_ff <= gray_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_level = gray_ff;

endmodule

`default_nettype wire

FILE: tb/tb_mandelbrot_escape_time.sv
// Self-checking testbench for the Mandelbrot escape-time pixel shader.
// Predicts each gray level in Q5.27 fixed point and checks it against the rsp_ beat.
// Depends on mbet_pkg and mandelbrot_escape_time.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
   import mbet_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_CENTER_REAL = CSR_ADDR_W'(REG_CENTER_REAL) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CENTER_IMAG = CSR_ADDR_W'(REG_CENTER_IMAG) << 2;
   localparam longint PIXEL_SCALE = 200;
   localparam longint COORD_MAX   = 64'sd2147483647;
   localparam longint COORD_MIN   = -64'sd2147483648;
   localparam int     MAX_REPORTS = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_X_W-1:0]    req_pixel_x = '0;
   logic [PIX_Y_W-1:0]    req_pixel_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [GRAY_W-1:0]     rsp_gray_level;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Local copy of the view center, updated on each register write
   logic signed [CENTER_W-1:0] view_real = CENTER_REAL_RESET;
   logic signed [CENTER_W-1:0] view_imag = CENTER_IMAG_RESET;

   logic [GRAY_W-1:0] pending_gray[$];
   int  errors = 0;
   int  pixels_checked = 0;
   int  never_escaped = 0;
   int  escaped_at_once = 0;
   int  center_settings = 0;
   int  stall_left = 0;
   bit  gap_bursts_on = 1'b0;
   bit  stall_bursts_on = 1'b0;

   mandelbrot_escape_time u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray_level (rsp_gray_level),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Clamp to the signed 32-bit coordinate range
   function automatic longint clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   // Offset d * 2^27 / 200, rounded to nearest with ties away from zero
   function automatic longint pixel_step(input int d);
      longint num;
      longint mag;
      longint q;
      num = longint'(d) * (longint'(1) <<< FRAC_BITS);
      mag = (num < 0) ? -num : num;
      q = (mag + PIXEL_SCALE / 2) / PIXEL_SCALE;
      return (num < 0) ? -q : q;
   endfunction

   // Escape-time loop: test |z|^2 > 4 before each update, floor back to Q5.27
   function automatic logic [GRAY_W-1:0] escape_gray(input logic [PIX_X_W-1:0] px,
                                                     input logic [PIX_Y_W-1:0] py);
      longint cr;
      longint ci;
      longint zr;
      longint zi;
      longint rr;
      longint ii;
      longint ri;
      logic [PROD_W:0] mag2;
      int n;
      cr = clamp_coord(longint'(view_real) + pixel_step(int'(px) - HALF_WIDTH));
      ci = clamp_coord(longint'(view_imag) + pixel_step(int'(py) - HALF_HEIGHT));
      zr = 0;
      zi = 0;
      n = 0;
      while (n < MAX_ITER) begin
         rr = zr * zr;
         ii = zi * zi;
         mag2 = {1'b0, rr} + {1'b0, ii};
         if (mag2 > ESCAPE_LIMIT) begin
            break;
         end
         ri = zr * zi;
         zr = clamp_coord(((rr - ii) >>> FRAC_BITS) + cr);
         zi = clamp_coord(((2 * ri) >>> FRAC_BITS) + ci);
         n++;
      end
      return GRAY_W'(MAX_ITER - n);
   endfunction

   // Check each accepted result beat and drive the result-side stall bursts
   always @(posedge clock) begin : check_gray
      logic [GRAY_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gray.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: gray_level beat with no pixel pending: expected none, actual %0d",
                        $time, rsp_gray_level);
            end
         end else begin
            want = pending_gray.pop_front();
            pixels_checked++;
            if (want == 0) begin
               never_escaped++;
            end
            if (want == GRAY_W'(MAX_ITER - 1)) begin
               escaped_at_once++;
            end
            if (rsp_gray_level !== want) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("%0t: gray_level mismatch: expected %0d, actual %0d",
                           $time, want, rsp_gray_level);
               end
            end
         end
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Send one pixel beat, with an optional gap ahead of it
   task automatic send_pixel(input logic [PIX_X_W-1:0] px, input logic [PIX_Y_W-1:0] py);
      if (gap_bursts_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (req_stall);
      pending_gray.push_back(escape_gray(px, py));
   endtask

   // Mostly on-screen pixels, some anywhere in the field range
   task automatic send_random(input int count);
      logic [PIX_X_W-1:0] px;
      logic [PIX_Y_W-1:0] py;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            px = PIX_X_W'($urandom_range(0, 1023));
            py = PIX_Y_W'($urandom_range(0, 511));
         end else begin
            px = PIX_X_W'($urandom_range(0, 2 * HALF_WIDTH - 1));
            py = PIX_Y_W'($urandom_range(0, 2 * HALF_HEIGHT - 1));
         end
         send_pixel(px, py);
      end
   endtask

   // Drop valid and let every pending result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_gray.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a center register, then read it back
   task automatic program_center(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_CENTER_REAL) begin
         view_real = value[CENTER_W-1:0];
      end else begin
         view_imag = value[CENTER_W-1:0];
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[CENTER_W-1:0] !== value[CENTER_W-1:0]) begin
         errors++;
         $display("%0t: readback of register at %0d: expected %h, actual %h",
                  $time, addr, value[CENTER_W-1:0], csr_prdata[CENTER_W-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Move the view center, then render random pixels around it
   task automatic run_view(input logic [31:0] re, input logic [31:0] im, input int count);
      wait_idle();
      program_center(ADDR_CENTER_REAL, re);
      program_center(ADDR_CENTER_IMAG, im);
      center_settings++;
      send_random(count);
   endtask

   // Corners, the view center, out-of-range fields and bit patterns at reset center
   task automatic test_directed_pixels();
      logic [PIX_X_W-1:0] xs[16];
      logic [PIX_Y_W-1:0] ys[16];
      xs = '{0, 639, 1023, 1023, 0, 320, 320, 0, 639, 320, 512, 341, 682, 255, 384, 200};
      ys = '{0, 479, 511, 0, 511, 240, 0, 240, 240, 479, 256, 170, 341, 128, 300, 240};
      center_settings++;
      for (int i = 0; i < 16; i++) begin
         send_pixel(xs[i], ys[i]);
      end
   endtask

   // Centers at +/-2.0 and at the ends of the 30-bit field, junk in the upper bits
   task automatic test_center_extremes();
      run_view(32'h1000_0000, 32'h1000_0000, 30);
      run_view(32'hF000_0000, 32'hF000_0000, 30);
      run_view(32'hDFFF_FFFF, 32'hE000_0000, 30);
      run_view(32'hE000_0000, 32'hDFFF_FFFF, 30);
      run_view(32'h0000_0000, 32'h0000_0000, 30);
      run_view(32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
               32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000, 30);
   endtask

   // Bulk of the run: full view around the set with idling on both sides
   task automatic test_random_views();
      gap_bursts_on   = 1'b1;
      stall_bursts_on = 1'b1;
      run_view(32'(CENTER_REAL_RESET), 32'(CENTER_IMAG_RESET), 700);
      run_view(32'hFC00_0000, 32'h0400_0000, 300);
      run_view(32'hF600_0000, 32'h0000_0000, 300);
   endtask

   // Back-to-back beats with no idling at all
   task automatic test_steady_stream();
      gap_bursts_on   = 1'b0;
      stall_bursts_on = 1'b0;
      run_view(32'(CENTER_REAL_RESET), 32'(CENTER_IMAG_RESET), 154);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_pixels();
      test_center_extremes();
      test_random_views();
      test_steady_stream();
      wait_idle();
      repeat (40) @(posedge clock);
      $display("Checked %0d pixels over %0d view centers: %0d never escaped, %0d escaped at once.",
               pixels_checked, center_settings, never_escaped, escaped_at_once);
      if (errors == 0) begin
         $display("[mandelbrot_escape_time] OK");
      end else begin
         $display("[mandelbrot_escape_time] ERROR");
      end
      $finish;
   end

   // Hard stop, several times the slowest legal run
   initial begin
      #200_000_000;
      $display("Timeout with %0d results still pending.", pending_gray.size());
      $display("[mandelbrot_escape_time] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
design/mbet_pkg.sv
design/mbet_mul.sv
design/mbet_csr.sv
design/mbet_core.sv
design/mandelbrot_escape_time.sv
tb/tb_mandelbrot_escape_time.sv
